// ===== src/lcg64_generator_with_seeding_unit_defines.svh =====
// Assertion macros shared by the LCG generator RTL.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef LCG64_GENERATOR_WITH_SEEDING_UNIT_DEFINES_SVH
`define LCG64_GENERATOR_WITH_SEEDING_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define LCG_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define LCG_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== src/lcg64_pkg.sv =====
// Package for the 64-bit LCG generator: constants, operation codes and sequencer types.
// No dependencies.
package lcg64_pkg;

  localparam logic [63:0] LcgMul = 64'd13624260627007768477;
  localparam logic [63:0] LcgAdd = 64'd8407169572674124741;
  localparam logic [63:0] HashK1 = 64'd4110542893;
  localparam logic [63:0] HashK2 = 64'd3667735229;
  localparam logic [63:0] HashK3 = 64'd4068774709;
  localparam logic [63:0] HashK4 = 64'd3322924477;

  localparam int unsigned SeedWords    = 10;
  localparam int unsigned SeedAdvances = 13;

  typedef enum logic [2:0] {
    OP_SEED   = 3'd0,
    OP_NEXT64 = 3'd1,
    OP_NEXT32 = 3'd2,
    OP_SET    = 3'd3,
    OP_GET    = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_PREP,
    ST_FINISH
  } fsm_t;

  // What the running multiply-add is computing.
  typedef enum logic [2:0] {
    PH_NEXT64,
    PH_NEXT32,
    PH_SEED_INIT,
    PH_SEED_ZFIX,
    PH_SEED_LOOP,
    PH_SEED_ADV
  } phase_t;

  typedef enum logic [1:0] {
    MS_LO_LO = 2'd0,
    MS_HI_LO = 2'd1,
    MS_LO_HI = 2'd2
  } mstep_t;

endpackage

// ===== src/lcg64_generator_with_seeding_unit.sv =====
// 64-bit LCG generator with hashed seeding, top level and only module.
// Depends on lcg64_pkg and lcg64_generator_with_seeding_unit_defines.svh.

// One item is taken at a time; in_tready is high only while the sequencer is idle.
// All arithmetic runs through one 32x32 multiplier with a 64-bit accumulator, and a
// 64-bit multiply-add mod 2^64 takes three passes. Get, set and unused operation codes
// go straight to the finish state; next 64-bit and next 32-bit run one multiply-add.
// Seeding runs a multiply-add for the first hash word, one for the zero check, a prep
// step and a multiply-add per hash-chain word (10 words, up to 20 with rejected words),
// then 13 advances; the chain ends early when it stalls on a zero word that maps to itself.
// The result register lets the block compute an item while the previous result still
// waits to be taken; the new result is held until the output is free.
module lcg64_generator_with_seeding_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [63:0] value
  input  logic [2:0]  in_tuser,   // [2:0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // [63:0] result_value
);

  `include "lcg64_generator_with_seeding_unit_defines.svh"

  lcg64_pkg::fsm_t   fsm_r, fsm_nxt;
  lcg64_pkg::phase_t phase_r, phase_nxt;
  lcg64_pkg::mstep_t step_r, step_nxt;

  logic [63:0] state_r, state_nxt;
  logic [63:0] seed_r, seed_nxt;
  logic [63:0] chain_r, chain_nxt;
  logic [63:0] mac_a_r, mac_a_nxt;
  logic [63:0] mac_b_r, mac_b_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [63:0] res_r, res_nxt;
  logic [29:0] kept7_r, kept7_nxt;
  logic [3:0]  count_r, count_nxt;
  logic [3:0]  adv_cnt_r, adv_cnt_nxt;
  logic        zfix_r, zfix_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_data_r, out_data_nxt;

  logic [31:0] mul_x, mul_y;
  logic [63:0] prod, addend, acc_sum;
  logic        in_xfer, mac_done, out_free, word_ok, seed_end, adv_last;

  assign in_tready  = (fsm_r == lcg64_pkg::ST_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_free   = !out_valid_r || out_tready;

  // Shared multiplier: low x low, high x low, low x high; upper cross terms fall off mod 2^64.
  always_comb begin
    case (step_r)
      lcg64_pkg::MS_HI_LO: begin
        mul_x = mac_a_r[63:32];
        mul_y = mac_b_r[31:0];
      end
      lcg64_pkg::MS_LO_HI: begin
        mul_x = mac_a_r[31:0];
        mul_y = mac_b_r[63:32];
      end
      default: begin
        mul_x = mac_a_r[31:0];
        mul_y = mac_b_r[31:0];
      end
    endcase
  end

  assign prod     = {32'h0, mul_x} * {32'h0, mul_y};
  assign addend   = (step_r == lcg64_pkg::MS_LO_LO) ? prod : {prod[31:0], 32'h0};
  assign acc_sum  = acc_r + addend;
  assign mac_done = (fsm_r == lcg64_pkg::ST_MAC) && (step_r == lcg64_pkg::MS_LO_HI);
  assign word_ok  = (acc_sum[29:0] != 30'h0);
  assign seed_end = (word_ok && (count_r == 4'(lcg64_pkg::SeedWords - 1)))
                 || (!word_ok && zfix_r);
  assign adv_last = (adv_cnt_r == 4'(lcg64_pkg::SeedAdvances - 1));

  // Next state.
  always_comb begin
    fsm_nxt = fsm_r;
    case (fsm_r)
      lcg64_pkg::ST_IDLE: begin
        if (in_xfer) begin
          case (in_tuser)
            lcg64_pkg::OP_SEED, lcg64_pkg::OP_NEXT64, lcg64_pkg::OP_NEXT32:
              fsm_nxt = lcg64_pkg::ST_MAC;
            default: fsm_nxt = lcg64_pkg::ST_FINISH;
          endcase
        end
      end
      lcg64_pkg::ST_MAC: begin
        if (mac_done) begin
          case (phase_r)
            lcg64_pkg::PH_NEXT64, lcg64_pkg::PH_NEXT32: fsm_nxt = lcg64_pkg::ST_FINISH;
            lcg64_pkg::PH_SEED_INIT: fsm_nxt = lcg64_pkg::ST_MAC;
            lcg64_pkg::PH_SEED_ZFIX: fsm_nxt = lcg64_pkg::ST_PREP;
            lcg64_pkg::PH_SEED_LOOP:
              fsm_nxt = seed_end ? lcg64_pkg::ST_MAC : lcg64_pkg::ST_PREP;
            lcg64_pkg::PH_SEED_ADV:
              fsm_nxt = adv_last ? lcg64_pkg::ST_FINISH : lcg64_pkg::ST_MAC;
            default: fsm_nxt = lcg64_pkg::ST_FINISH;
          endcase
        end
      end
      lcg64_pkg::ST_PREP: fsm_nxt = lcg64_pkg::ST_MAC;
      lcg64_pkg::ST_FINISH: begin
        if (out_free) begin
          fsm_nxt = lcg64_pkg::ST_IDLE;
        end
      end
      default: fsm_nxt = lcg64_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    phase_nxt     = phase_r;
    step_nxt      = step_r;
    state_nxt     = state_r;
    seed_nxt      = seed_r;
    chain_nxt     = chain_r;
    mac_a_nxt     = mac_a_r;
    mac_b_nxt     = mac_b_r;
    acc_nxt       = acc_r;
    res_nxt       = res_r;
    kept7_nxt     = kept7_r;
    count_nxt     = count_r;
    adv_cnt_nxt   = adv_cnt_r;
    zfix_nxt      = zfix_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;

    case (fsm_r)
      lcg64_pkg::ST_IDLE: begin
        if (in_xfer) begin
          res_nxt  = 64'h0;
          step_nxt = lcg64_pkg::MS_LO_LO;
          case (in_tuser)
            lcg64_pkg::OP_SEED: begin
              seed_nxt  = in_tdata;
              mac_a_nxt = in_tdata + lcg64_pkg::HashK1;
              mac_b_nxt = lcg64_pkg::HashK2;
              acc_nxt   = lcg64_pkg::HashK3;
              phase_nxt = lcg64_pkg::PH_SEED_INIT;
              count_nxt = 4'd0;
              kept7_nxt = 30'h0;
            end
            lcg64_pkg::OP_NEXT64, lcg64_pkg::OP_NEXT32: begin
              mac_a_nxt = state_r;
              mac_b_nxt = lcg64_pkg::LcgMul;
              acc_nxt   = lcg64_pkg::LcgAdd;
              phase_nxt = (in_tuser == lcg64_pkg::OP_NEXT64) ? lcg64_pkg::PH_NEXT64
                                                             : lcg64_pkg::PH_NEXT32;
            end
            lcg64_pkg::OP_SET: state_nxt = in_tdata;
            lcg64_pkg::OP_GET: res_nxt = state_r;
            default: res_nxt = 64'h0;
          endcase
        end
      end
      lcg64_pkg::ST_MAC: begin
        if (!mac_done) begin
          acc_nxt  = acc_sum;
          step_nxt = (step_r == lcg64_pkg::MS_LO_LO) ? lcg64_pkg::MS_HI_LO
                                                     : lcg64_pkg::MS_LO_HI;
        end else begin
          step_nxt = lcg64_pkg::MS_LO_LO;
          case (phase_r)
            lcg64_pkg::PH_NEXT64: begin
              state_nxt = acc_sum;
              res_nxt   = acc_sum;
            end
            lcg64_pkg::PH_NEXT32: begin
              state_nxt = acc_sum;
              res_nxt   = {32'h0, acc_sum[63:32]};
            end
            lcg64_pkg::PH_SEED_INIT: begin
              chain_nxt = acc_sum;
              mac_a_nxt = seed_r;
              mac_b_nxt = lcg64_pkg::HashK3;
              acc_nxt   = lcg64_pkg::HashK4;
              phase_nxt = lcg64_pkg::PH_SEED_ZFIX;
            end
            lcg64_pkg::PH_SEED_ZFIX: begin
              // A zero low word mapping to itself would stall the chain for good.
              zfix_nxt  = !word_ok;
              phase_nxt = lcg64_pkg::PH_SEED_LOOP;
            end
            lcg64_pkg::PH_SEED_LOOP: begin
              chain_nxt = acc_sum;
              if (word_ok) begin
                count_nxt = count_r + 4'd1;
                if (count_r == 4'(lcg64_pkg::SeedWords - 3)) begin
                  kept7_nxt = acc_sum[29:0];
                end
              end
              if (seed_end) begin
                // Word ten only counts if it was accepted here; otherwise it is zero.
                mac_a_nxt   = word_ok ? {1'b0, acc_sum[30:0], 2'b00, kept7_r}
                                      : {34'h0, kept7_r};
                mac_b_nxt   = lcg64_pkg::LcgMul;
                acc_nxt     = lcg64_pkg::LcgAdd;
                adv_cnt_nxt = 4'd0;
                phase_nxt   = lcg64_pkg::PH_SEED_ADV;
              end
            end
            lcg64_pkg::PH_SEED_ADV: begin
              state_nxt = acc_sum;
              res_nxt   = 64'h0;
              if (!adv_last) begin
                adv_cnt_nxt = adv_cnt_r + 4'd1;
                mac_a_nxt   = acc_sum;
                mac_b_nxt   = lcg64_pkg::LcgMul;
                acc_nxt     = lcg64_pkg::LcgAdd;
              end
            end
            default: res_nxt = 64'h0;
          endcase
        end
      end
      lcg64_pkg::ST_PREP: begin
        mac_a_nxt = seed_r + chain_r;
        mac_b_nxt = lcg64_pkg::HashK3;
        acc_nxt   = lcg64_pkg::HashK4;
        step_nxt  = lcg64_pkg::MS_LO_LO;
      end
      lcg64_pkg::ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
        end
      end
      default: res_nxt = res_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r       <= lcg64_pkg::ST_IDLE;
      phase_r     <= lcg64_pkg::PH_NEXT64;
      step_r      <= lcg64_pkg::MS_LO_LO;
      state_r     <= 64'h0;
      count_r     <= 4'd0;
      adv_cnt_r   <= 4'd0;
      zfix_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      fsm_r       <= fsm_nxt;
      phase_r     <= phase_nxt;
      step_r      <= step_nxt;
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      adv_cnt_r   <= adv_cnt_nxt;
      zfix_r      <= zfix_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seed_r     <= seed_nxt;
    chain_r    <= chain_nxt;
    mac_a_r    <= mac_a_nxt;
    mac_b_r    <= mac_b_nxt;
    acc_r      <= acc_nxt;
    res_r      <= res_nxt;
    kept7_r    <= kept7_nxt;
    out_data_r <= out_data_nxt;
  end

  `LCG_ASSERT_NEXT(a_mac_steps,
    fsm_r == lcg64_pkg::ST_MAC && step_r != lcg64_pkg::MS_LO_HI,
    fsm_r == lcg64_pkg::ST_MAC && step_r != lcg64_pkg::MS_LO_LO,
    "multiply-add left before its third pass")
  `LCG_ASSERT_NEXT(a_finish_holds,
    fsm_r == lcg64_pkg::ST_FINISH && out_valid_r && !out_tready,
    fsm_r == lcg64_pkg::ST_FINISH && $stable(res_r),
    "result dropped while output was occupied")
  `LCG_ASSERT_NOW(a_count_range,
    fsm_r == lcg64_pkg::ST_MAC && phase_r == lcg64_pkg::PH_SEED_LOOP,
    count_r < 4'(lcg64_pkg::SeedWords),
    "seed word count overran")
  `LCG_ASSERT_NEXT(a_seed_start,
    in_xfer && in_tuser == lcg64_pkg::OP_SEED,
    fsm_r == lcg64_pkg::ST_MAC && phase_r == lcg64_pkg::PH_SEED_INIT,
    "seed transfer did not start the hash chain")

endmodule

// ===== dv/lcg64_generator_with_seeding_unit_tb.sv =====
// Self-checking testbench for lcg64_generator_with_seeding_unit: directed, back-pressure and
// random traffic, checked against a cycle-free model of the generator held in this file.
// Depends on lcg64_pkg and the RTL of the block only.
module lcg64_generator_with_seeding_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ClkHalf    = 5;
  localparam int unsigned DrainLimit = 5000;
  localparam int unsigned TailCycles = 40;
  localparam int unsigned LongHold   = 300;
  localparam longint unsigned TimeoutNs = 64'd20_000_000;

  // Operation codes the block does not use.
  localparam logic [2:0] OpSpare5 = 3'd5;
  localparam logic [2:0] OpSpare6 = 3'd6;
  localparam logic [2:0] OpSpare7 = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;   // [63:0] value
  logic [2:0]  in_tuser = '0;   // [2:0] operation
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;       // [63:0] result_value

  logic [63:0] expected_words [$];
  logic [63:0] model_state = '0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_req = 1'b0;
  int unsigned hold_left = 0;

  int unsigned n_errors = 0;
  int unsigned n_sent = 0;
  int unsigned n_checked = 0;
  int unsigned op_count [8];
  int unsigned rejected_words = 0;
  int unsigned zero_fixed_seeds = 0;
  int unsigned stalled_seeds = 0;

  lcg64_generator_with_seeding_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #(ClkHalf) clk = ~clk;

  // ---------------------------------------------------------------- generator model

  function automatic void reseed_model(input logic [63:0] seed);
    logic [31:0] kept [lcg64_pkg::SeedWords];
    int unsigned n_kept;
    logic [63:0] chain;
    logic        zero_fixed;
    n_kept = 0;
    for (int i = 0; i < lcg64_pkg::SeedWords; i++) kept[i] = '0;
    chain = (seed + lcg64_pkg::HashK1) * lcg64_pkg::HashK2 + lcg64_pkg::HashK3;
    zero_fixed = ((seed * lcg64_pkg::HashK3 + lcg64_pkg::HashK4) & 64'h3FFF_FFFF) == 64'd0;
    if (zero_fixed) zero_fixed_seeds++;
    while (n_kept < lcg64_pkg::SeedWords) begin
      chain = (seed + chain) * lcg64_pkg::HashK3 + lcg64_pkg::HashK4;
      if (chain[29:0] != 30'd0) begin
        kept[n_kept] = chain[31:0];
        n_kept++;
      end else begin
        rejected_words++;
        // A zero word that maps onto itself would stall the chain for good.
        if (zero_fixed) begin
          stalled_seeds++;
          break;
        end
      end
    end
    model_state = {1'b0, kept[9][30:0], 2'b00, kept[7][29:0]};
    repeat (lcg64_pkg::SeedAdvances)
      model_state = model_state * lcg64_pkg::LcgMul + lcg64_pkg::LcgAdd;
  endfunction

  function automatic logic [63:0] model_lcg_op(input logic [2:0] op_code,
                                              input logic [63:0] value);
    logic [63:0] reply;
    reply = '0;
    case (op_code)
      lcg64_pkg::OP_SEED: reseed_model(value);
      lcg64_pkg::OP_NEXT64: begin
        model_state = model_state * lcg64_pkg::LcgMul + lcg64_pkg::LcgAdd;
        reply = model_state;
      end
      lcg64_pkg::OP_NEXT32: begin
        model_state = model_state * lcg64_pkg::LcgMul + lcg64_pkg::LcgAdd;
        reply = {32'd0, model_state[63:32]};
      end
      lcg64_pkg::OP_SET: model_state = value;
      lcg64_pkg::OP_GET: reply = model_state;
      default: ;
    endcase
    return reply;
  endfunction

  // ---------------------------------------------------------------- seed construction

  // Hash-chain word number idx for a seed, with no words rejected on the way.
  function automatic logic [63:0] raw_chain_word(input logic [63:0] seed, input int unsigned idx);
    logic [63:0] chain;
    chain = (seed + lcg64_pkg::HashK1) * lcg64_pkg::HashK2 + lcg64_pkg::HashK3;
    repeat (idx) chain = (seed + chain) * lcg64_pkg::HashK3 + lcg64_pkg::HashK4;
    return chain;
  endfunction

  // A seed s with the low 30 bits of slope*s + offset all zero; slope must be odd.
  // Upper seed bits do not reach the low 30 bits of any chain word, so they stay random.
  function automatic logic [63:0] zeroing_seed(input logic [63:0] slope,
                                              input logic [63:0] offset);
    logic [63:0] inv;
    inv = slope;
    repeat (6) inv = inv * (64'd2 - slope * inv);
    return ({$urandom, $urandom} & ~64'h3FFF_FFFF) | (((-offset) * inv) & 64'h3FFF_FFFF);
  endfunction

  // Chain words are affine in the seed; at even word numbers the slope is odd, so a seed
  // can be solved for whose word at that position is rejected.
  function automatic logic [63:0] rejecting_seed(input int unsigned word_idx);
    logic [63:0] base;
    logic [63:0] slope;
    base  = raw_chain_word(64'd0, word_idx);
    slope = raw_chain_word(64'd1, word_idx) - base;
    return zeroing_seed(slope, base);
  endfunction

  function automatic logic [63:0] random_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return {32'd0, $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // ---------------------------------------------------------------- driving and checking

  task automatic send_item(input logic [2:0] op_code, input logic [63:0] value);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tuser  <= op_code;
    do @(posedge clk); while (!in_tready);
    expected_words.push_back(model_lcg_op(op_code, value));
    op_count[op_code]++;
    n_sent++;
  endtask

  task automatic wait_drained();
    int unsigned waited;
    waited = 0;
    in_tvalid <= 1'b0;
    do begin
      @(posedge clk);
      waited++;
    end while (expected_words.size() != 0 && waited < DrainLimit);
    if (expected_words.size() != 0) begin
      $display("%0t: %0d results still outstanding after %0d cycles", $time,
               expected_words.size(), waited);
      n_errors++;
    end
  endtask

  // Result side: compare each transfer, then decide whether to stall the next cycle.
  always @(posedge clk) begin
    logic [63:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h", $time, out_tdata);
        n_errors++;
      end else begin
        want = expected_words.pop_front();
        n_checked++;
        if (out_tdata !== want) begin
          $display("%0t: result_value mismatch: expected %h, actual %h", $time, want,
                   out_tdata);
          n_errors++;
        end
      end
    end
    if (hold_req) hold_left = LongHold;
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_after_reset();
    send_item(lcg64_pkg::OP_GET, random_word());
    send_item(lcg64_pkg::OP_NEXT64, random_word());
    send_item(lcg64_pkg::OP_NEXT32, random_word());
    wait_drained();
  endtask

  task automatic test_state_access();
    send_item(lcg64_pkg::OP_SET, 64'd0);
    send_item(lcg64_pkg::OP_GET, '1);
    send_item(lcg64_pkg::OP_SET, '1);
    send_item(lcg64_pkg::OP_GET, '0);
    send_item(lcg64_pkg::OP_NEXT64, random_word());
    send_item(lcg64_pkg::OP_NEXT32, random_word());
    wait_drained();
  endtask

  task automatic test_unused_codes();
    send_item(OpSpare5, '1);
    send_item(OpSpare6, random_word());
    send_item(OpSpare7, '1);
    send_item(lcg64_pkg::OP_GET, random_word());
    wait_drained();
  endtask

  task automatic test_seeding();
    send_item(lcg64_pkg::OP_SEED, 64'd0);
    send_item(lcg64_pkg::OP_NEXT64, '0);
    send_item(lcg64_pkg::OP_SEED, '1);
    send_item(lcg64_pkg::OP_GET, '0);
    // Zero is a fixed point of the chain's low bits for this seed.
    send_item(lcg64_pkg::OP_SEED, zeroing_seed(lcg64_pkg::HashK3, lcg64_pkg::HashK4));
    send_item(lcg64_pkg::OP_GET, '0);
    send_item(lcg64_pkg::OP_SEED, rejecting_seed(2));
    send_item(lcg64_pkg::OP_SEED, rejecting_seed(4));
    send_item(lcg64_pkg::OP_NEXT32, '1);
    wait_drained();
  endtask

  // The receiver holds off for a long stretch while items keep coming, so the block
  // fills up and has to stall its input.
  task automatic test_full_backpressure();
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    for (int i = 0; i < 12; i++) begin
      send_item(i % 2 ? lcg64_pkg::OP_NEXT64 : lcg64_pkg::OP_NEXT32, random_word());
    end
    send_item(lcg64_pkg::OP_SEED, random_word());
    send_item(lcg64_pkg::OP_GET, '0);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int unsigned n_items, input int unsigned idle_pct,
                                     input int unsigned stall_pct);
    int unsigned pick;
    logic [2:0]  op;
    logic [63:0] value;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n_items; i++) begin
      pick  = $urandom_range(0, 99);
      value = random_word();
      if (pick < 30) op = lcg64_pkg::OP_NEXT64;
      else if (pick < 60) op = lcg64_pkg::OP_NEXT32;
      else if (pick < 72) op = lcg64_pkg::OP_GET;
      else if (pick < 83) op = lcg64_pkg::OP_SET;
      else if (pick < 93) op = lcg64_pkg::OP_SEED;
      else begin
        case ($urandom_range(0, 2))
          0: op = OpSpare5;
          1: op = OpSpare6;
          default: op = OpSpare7;
        endcase
      end
      if (op == lcg64_pkg::OP_SEED && $urandom_range(0, 3) == 0) begin
        if ($urandom_range(0, 4) == 0) begin
          value = zeroing_seed(lcg64_pkg::HashK3, lcg64_pkg::HashK4);
        end else begin
          value = rejecting_seed($urandom_range(1, 5) * 2);
        end
      end
      send_item(op, value);
    end
    wait_drained();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    for (int i = 0; i < 8; i++) op_count[i] = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_after_reset();
    test_state_access();
    test_unused_codes();
    test_seeding();
    test_full_backpressure();
    test_random_traffic(450, 0, 0);
    test_random_traffic(450, 53, 0);
    test_random_traffic(450, 0, 53);
    test_random_traffic(450, 7, 7);

    repeat (TailCycles) @(posedge clk);

    $display("summary: %0d transfers in, %0d results checked (seed %0d, next64 %0d,",
             n_sent, n_checked, op_count[lcg64_pkg::OP_SEED],
             op_count[lcg64_pkg::OP_NEXT64]);
    $display("summary: next32 %0d, set %0d, get %0d, spare codes %0d); %0d rejected %s",
             op_count[lcg64_pkg::OP_NEXT32], op_count[lcg64_pkg::OP_SET],
             op_count[lcg64_pkg::OP_GET],
             op_count[OpSpare5] + op_count[OpSpare6] + op_count[OpSpare7], rejected_words,
             "chain words");
    $display("summary: %0d seeds with a fixed zero, %0d of them stalled the chain",
             zero_fixed_seeds, stalled_seeds);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #(TimeoutNs);
    $display("timeout after %0d ns", TimeoutNs);
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/lcg64_pkg.sv
src/lcg64_generator_with_seeding_unit.sv
dv/lcg64_generator_with_seeding_unit_tb.sv
